[rtl/cbdoam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbdoam_pkg: shared types and constants of the console bus decoder
// Item structs, target and request codes, memory sizing and state types.
// ----------------------------------------------------------------------------
package cbdoam_pkg;

	// Work RAM sizing (power of two, 256 to 8192 entries)
	localparam int RamAw    = 11;
	localparam int RamDepth = 1 << RamAw;

	// Configuration register indexes
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_POWER = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_CART  = 1'd1;

	// Bus map
	localparam logic [15:0] AddrRamTop  = 16'h1FFF;
	localparam logic [15:0] AddrPpuTop  = 16'h3FFF;
	localparam logic [15:0] AddrApuTop  = 16'h401F;
	localparam logic [15:0] AddrDma     = 16'h4014;
	localparam logic [15:0] AddrPad1    = 16'h4016;
	localparam logic [15:0] AddrPad2    = 16'h4017;
	localparam logic [15:0] AddrOamData = 16'h2004;
	localparam logic [15:0] DmaPtrReset = 16'hFFFF;
	localparam logic [7:0]  PageLast    = 8'hFF;

	// Request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_RAM  = 3'd1,
		TGT_PPU  = 3'd2,
		TGT_APU  = 3'd3,
		TGT_CART = 3'd4,
		TGT_PAD  = 3'd5,
		TGT_OPEN = 3'd6
	} tgt_t;

	typedef enum logic [1:0] {
		DMA_OFF = 2'd0,
		DMA_RD  = 2'd1,
		DMA_WR  = 2'd2
	} dma_st_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} fsm_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  pad1_buttons;
		logic [7:0]  pad2_buttons;
		logic [7:0]  return_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [15:0] bus_address;
		logic        bus_write;
		logic [7:0]  bus_data;
		logic        cpu_step;
		logic        apu_step;
		logic        ppu_step;
		logic        cart_step;
		logic        dma_busy;
	} out_item_t;

	// Architectural state outside the work RAM
	typedef struct packed {
		logic [7:0]  pad1_shift;
		logic [7:0]  pad2_shift;
		logic [1:0]  clock_phase;
		logic [15:0] dma_pointer;
		logic [7:0]  dma_byte;
		dma_st_t     dma_state;
		logic        dma_ext;
	} bus_state_t;

	typedef struct packed {
		logic power_enable;
		logic cart_present;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic [RamAw-1:0] addr;
		logic [7:0]       data;
	} ram_wr_t;

endpackage

[rtl/cbdoam_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbdoam_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbdoam_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/cbdoam_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbdoam_step: per-item bus decode and state update
// Decodes one item against the current state and the RAM read data, and
// produces the result, the next state and the work RAM write.
// ----------------------------------------------------------------------------
module cbdoam_step (
	input  cbdoam_pkg::in_item_t   item,
	input  cbdoam_pkg::bus_state_t st,
	input  cbdoam_pkg::cfg_t       cfg,
	input  logic [7:0]             ram_rdata,
	output cbdoam_pkg::bus_state_t nxt,
	output cbdoam_pkg::out_item_t  res,
	output cbdoam_pkg::ram_wr_t    wr
);
	import cbdoam_pkg::*;

	function automatic tgt_t decode(input logic [15:0] a, input logic cart);
		if (a <= AddrRamTop) return TGT_RAM;
		if (a <= AddrPpuTop) return TGT_PPU;
		if (a <= AddrApuTop) return (a == AddrPad1 || a == AddrPad2) ? TGT_PAD : TGT_APU;
		return cart ? TGT_CART : TGT_OPEN;
	endfunction

	logic [15:0] rd_addr;
	tgt_t        rd_tgt;
	logic [15:0] rd_fa;
	logic [7:0]  rd_data;
	logic [7:0]  rd_pad1;
	logic [7:0]  rd_pad2;
	tgt_t        wr_tgt;
	logic [1:0]  phase_n;
	logic        apu_s;
	dma_st_t     dma_cur;

	// shared read path: DMA read ticks use the pointer, reads use the address
	always_comb begin
		rd_addr = (item.req_type == REQ_TICK) ? st.dma_pointer : item.address;
		rd_tgt  = decode(rd_addr, cfg.cart_present);
		rd_fa   = rd_addr;
		rd_data = 8'h00;
		rd_pad1 = st.pad1_shift;
		rd_pad2 = st.pad2_shift;
		if (rd_tgt == TGT_RAM) begin
			rd_fa   = 16'(rd_addr[RamAw-1:0]);
			rd_data = ram_rdata;
		end else if (rd_tgt == TGT_PAD) begin
			// serial pad: bit 0 out, ones shift in at the top
			if (rd_addr == AddrPad1) begin
				rd_data = {7'd0, st.pad1_shift[0]};
				rd_pad1 = {1'b1, st.pad1_shift[7:1]};
			end else begin
				rd_data = {7'd0, st.pad2_shift[0]};
				rd_pad2 = {1'b1, st.pad2_shift[7:1]};
			end
		end
	end

	assign wr_tgt  = decode(item.address, cfg.cart_present);
	assign phase_n = (st.clock_phase >= 2'd2) ? 2'd0 : st.clock_phase + 2'd1;
	assign apu_s   = (phase_n == 2'd0);

	always_comb begin
		case (st.dma_state)
			DMA_RD:  dma_cur = DMA_RD;
			DMA_WR:  dma_cur = DMA_WR;
			default: dma_cur = DMA_OFF;
		endcase
	end

	// item execution
	always_comb begin
		nxt           = st;
		nxt.dma_state = dma_cur;
		res           = '0;
		wr.we         = 1'b0;
		wr.addr       = item.address[RamAw-1:0];
		wr.data       = item.write_data;
		case (item.req_type)
			REQ_TICK: begin
				if (cfg.power_enable) begin
					nxt.clock_phase = phase_n;
					res.ppu_step    = 1'b1;
					res.cart_step   = cfg.cart_present;
					res.apu_step    = apu_s;
					res.cpu_step    = apu_s && (dma_cur == DMA_OFF);
					if (dma_cur == DMA_RD) begin
						res.target      = rd_tgt;
						res.bus_address = rd_fa;
						res.bus_data    = rd_data;
						nxt.pad1_shift  = rd_pad1;
						nxt.pad2_shift  = rd_pad2;
						nxt.dma_byte    = rd_data;
						nxt.dma_ext     = (rd_tgt == TGT_PPU || rd_tgt == TGT_APU ||
							rd_tgt == TGT_CART);
						nxt.dma_state   = DMA_WR;
					end else if (dma_cur == DMA_WR) begin
						// external byte arrives on this tick
						if (st.dma_ext) begin
							nxt.dma_byte = item.return_data;
							nxt.dma_ext  = 1'b0;
						end
						res.target      = TGT_PPU;
						res.bus_address = AddrOamData;
						res.bus_write   = 1'b1;
						res.bus_data    = st.dma_ext ? item.return_data : st.dma_byte;
						if (st.dma_pointer[7:0] != PageLast) begin
							nxt.dma_pointer = st.dma_pointer + 16'd1;
							nxt.dma_state   = DMA_RD;
						end else begin
							nxt.dma_state = DMA_OFF;
						end
					end
				end
			end
			REQ_READ: begin
				res.target      = rd_tgt;
				res.bus_address = rd_fa;
				res.bus_data    = rd_data;
				nxt.pad1_shift  = rd_pad1;
				nxt.pad2_shift  = rd_pad2;
			end
			REQ_WRITE: begin
				res.bus_write   = 1'b1;
				res.bus_data    = item.write_data;
				res.bus_address = item.address;
				res.target      = wr_tgt;
				if (wr_tgt == TGT_RAM) begin
					res.bus_address = 16'(item.address[RamAw-1:0]);
					wr.we           = 1'b1;
				end else if (item.address == AddrDma) begin
					res.target      = TGT_NONE;
					nxt.dma_pointer = {item.write_data, 8'h00};
					nxt.dma_state   = DMA_RD;
					nxt.dma_ext     = 1'b0;
				end else if (item.address == AddrPad1) begin
					res.target = TGT_PAD;
					if (!item.write_data[0]) begin
						nxt.pad1_shift = item.pad1_buttons;
						nxt.pad2_shift = item.pad2_buttons;
					end
				end else if (item.address == AddrPad2) begin
					res.target = TGT_APU;
				end
			end
			default: begin
				// unused request code: no access
			end
		endcase
		res.dma_busy = (nxt.dma_state != DMA_OFF);
	end

endmodule

[rtl/console_bus_decode_oam_dma_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_bus_decode_oam_dma_core: system bus decoder with sprite DMA
// Work RAM, pad shifters, clock divider and sprite DMA sequencer; routes each
// tick or processor access and returns one result item per input item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall   in_item  (cbdoam_pkg::in_item_t)
//  out       output     out_valid / out_stall out_item (cbdoam_pkg::out_item_t)
//  cfg       input      cfg_we               cfg_index, cfg_data
//
//  An item is accepted, the work RAM is read, and on the next cycle the item
//  executes; its result enters the output register once that register is free,
//  and no new item is accepted until then. The work RAM read data is registered.
//  After reset a clearing pass writes zero to all RamDepth (2048) RAM entries,
//  one per cycle, with in_stall high; configuration writes are taken meanwhile.
//  A new item is accepted while a result waits in the output register; an
//  executed item waits in place while out_stall holds the output register full.
// ----------------------------------------------------------------------------
module console_bus_decode_oam_dma_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cbdoam_pkg::in_item_t               in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cbdoam_pkg::out_item_t              out_item,
	input  logic                               cfg_we,
	input  logic [cbdoam_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [0:0]                         cfg_data
);
	import cbdoam_pkg::*;

	fsm_t             state_q, state_d;
	logic [RamAw-1:0] clr_q;
	in_item_t         item_s1;
	bus_state_t       st_q, st_nxt;
	cfg_t             cfg_q;
	out_item_t        out_item_q, res;
	logic             out_valid_q;
	ram_wr_t          step_wr;
	logic             accept, commit, out_free;
	logic             ram_we;
	logic [RamAw-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == ST_EXEC) && out_free;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == {RamAw{1'b1}}) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + RamAw'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POWER: cfg_q.power_enable <= cfg_data[0];
				CFG_CART:  cfg_q.cart_present <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// accepted item
	always_ff @(posedge clk) begin
		if (accept) item_s1 <= in_item;
	end

	// work RAM ports: clearing pass, else the executing item's write
	assign ram_raddr = (in_item.req_type == REQ_TICK) ? st_q.dma_pointer[RamAw-1:0]
		: in_item.address[RamAw-1:0];
	assign ram_we    = (state_q == ST_CLEAR) || (commit && step_wr.we);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : step_wr.addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? 8'h00 : step_wr.data;

	cbdoam_ram #(
		.Width(8),
		.Depth(RamDepth)
	) u_work_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cbdoam_step u_step (
		.item      (item_s1),
		.st        (st_q),
		.cfg       (cfg_q),
		.ram_rdata (ram_rdata),
		.nxt       (st_nxt),
		.res       (res),
		.wr        (step_wr)
	);

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{pad1_shift: 8'h00, pad2_shift: 8'h00, clock_phase: 2'd0,
				dma_pointer: DmaPtrReset, dma_byte: 8'h00, dma_state: DMA_OFF,
				dma_ext: 1'b0};
		end else if (commit) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef NO_ASSERTIONS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted item did not enter execution");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && out_item_q.dma_busy == (st_q.dma_state != DMA_OFF))
		else $error("result register out of step with DMA state");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("work RAM written while idle");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && !out_free |=> state_q == ST_EXEC && $stable(st_q))
		else $error("state changed while result was blocked");
`endif

endmodule
